[rtl/core/i2cm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_NACK  = 3'd4,
    CMD_WACK  = 3'd5,
    CMD_WRITE = 3'd6,
    CMD_READ  = 3'd7
  } i2cm_cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BUS_BUSY   = 2'd1,
    ST_STUCK_HIGH = 2'd2
  } i2cm_start_t;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       sda_in;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic [1:0] start_status;
  } i2cm_out_t;

  typedef struct packed {
    i2cm_cmd_t   cmd;
    logic [2:0]  step;
    logic [3:0]  bit_cnt;
    logic [15:0] tick_cnt;
    logic [7:0]  shreg;
    logic [7:0]  rx_byte;
    logic        scl;
    logic        sda;
    logic        ack;
    i2cm_start_t start_code;
  } i2cm_state_t;

endpackage : i2cm_pkg
`default_nettype wire

[rtl/core/i2cm_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_step
// One tick of the bit engine: next engine state and the result word.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  var i2cm_pkg::i2cm_state_t st,
  input  var i2cm_pkg::i2cm_in_t    item,
  input  var logic [15:0]           phase_ticks,
  output i2cm_pkg::i2cm_state_t     st_nxt,
  output i2cm_pkg::i2cm_out_t       res
);
  import i2cm_pkg::*;

  // Line levels a phase sets; {scl, sda}.
  function automatic logic [1:0] phase_lvl(i2cm_cmd_t c, logic [2:0] s,
                                           logic [7:0] sh, logic scl, logic sda);
    logic [1:0] l;
    l = {scl, sda};
    case (c)
      CMD_START: l = (s == 3'd0) ? 2'b11 : {scl, 1'b0};
      CMD_STOP: begin
        case (s)
          3'd0:    l = {1'b0, sda};
          3'd1:    l = {scl, 1'b0};
          3'd2:    l = {1'b1, sda};
          default: l = {scl, 1'b1};
        endcase
      end
      CMD_ACK, CMD_NACK: begin
        case (s)
          3'd0:    l = {1'b0, sda};
          3'd1:    l = {scl, (c == CMD_NACK)};
          3'd2:    l = {1'b1, sda};
          default: l = {1'b0, sda};
        endcase
      end
      CMD_WACK: begin
        case (s)
          3'd0:    l = {1'b0, sda};
          3'd1:    l = {scl, 1'b1};
          default: l = {1'b1, sda};
        endcase
      end
      CMD_WRITE: l = (s == 3'd0) ? {1'b0, sh[7]} : {1'b1, sda};
      CMD_READ:  l = (s == 3'd0) ? 2'b01 : {1'b1, sda};
      default:   l = {scl, sda};
    endcase
    return l;
  endfunction

  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic [7:0]  sh_shift;
  logic [3:0]  bit_inc;
  logic        fin;
  logic        adv;
  logic [1:0]  lvl;

  always_comb begin
    st_nxt   = st;
    fin      = 1'b0;
    adv      = 1'b0;
    limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    tick_inc = st.tick_cnt + 16'd1;
    sh_shift = (st.cmd == CMD_READ) ? {st.shreg[6:0], item.sda_in}
                                    : {st.shreg[6:0], 1'b0};
    bit_inc  = st.bit_cnt + 4'd1;
    lvl      = 2'b11;

    if (st.cmd == CMD_IDLE) begin
      if (item.req_type != CMD_IDLE) begin
        st_nxt.cmd      = i2cm_cmd_t'(item.req_type);
        st_nxt.step     = 3'd0;
        st_nxt.bit_cnt  = 4'd0;
        st_nxt.tick_cnt = 16'd0;
        if (item.req_type == CMD_WRITE) begin
          st_nxt.shreg = item.tx_byte;
        end else if (item.req_type == CMD_READ) begin
          st_nxt.shreg = 8'd0;
        end
        lvl        = phase_lvl(i2cm_cmd_t'(item.req_type), 3'd0, st_nxt.shreg,
                               st.scl, st.sda);
        st_nxt.scl = lvl[1];
        st_nxt.sda = lvl[0];
      end
    end else begin
      st_nxt.tick_cnt = tick_inc;
      if (tick_inc >= limit) begin
        st_nxt.tick_cnt = 16'd0;
        adv = 1'b1;
        case (st.cmd)
          CMD_START: begin
            if (st.step == 3'd0 && !item.sda_in) begin
              st_nxt.start_code = ST_BUS_BUSY;
              fin = 1'b1;
            end else if (st.step == 3'd1 && item.sda_in) begin
              st_nxt.start_code = ST_STUCK_HIGH;
              fin = 1'b1;
            end else if (st.step == 3'd2) begin
              st_nxt.start_code = ST_OK;
              fin = 1'b1;
            end
          end
          CMD_STOP, CMD_ACK, CMD_NACK: fin = (st.step == 3'd3);
          CMD_WACK: begin
            if (st.step == 3'd2) begin
              st_nxt.ack = !item.sda_in;
              st_nxt.scl = 1'b0;
              fin = 1'b1;
            end
          end
          CMD_WRITE, CMD_READ: begin
            if (st.step == 3'd1) begin
              st_nxt.shreg   = sh_shift;
              st_nxt.bit_cnt = bit_inc;
              if (bit_inc >= BITS_PER_BYTE) begin
                if (st.cmd == CMD_READ) st_nxt.rx_byte = sh_shift;
                st_nxt.scl = 1'b0;
                fin = 1'b1;
              end else begin
                // next bit restarts at the low phase
                st_nxt.step = 3'd0;
                lvl         = phase_lvl(st.cmd, 3'd0, sh_shift, st.scl, st.sda);
                st_nxt.scl  = lvl[1];
                st_nxt.sda  = lvl[0];
                adv         = 1'b0;
              end
            end
          end
          default: fin = 1'b1;
        endcase

        if (fin) begin
          st_nxt.cmd     = CMD_IDLE;
          st_nxt.step    = 3'd0;
          st_nxt.bit_cnt = 4'd0;
        end else if (adv) begin
          st_nxt.step = st.step + 3'd1;
          lvl         = phase_lvl(st.cmd, st.step + 3'd1, st_nxt.shreg,
                                  st_nxt.scl, st_nxt.sda);
          st_nxt.scl  = lvl[1];
          st_nxt.sda  = lvl[0];
        end
      end
    end

    res.scl_out      = st_nxt.scl;
    res.sda_out      = st_nxt.sda;
    res.busy_res     = (st_nxt.cmd != CMD_IDLE);
    res.done_res     = fin;
    res.rx_byte      = st_nxt.rx_byte;
    res.ack_seen     = st_nxt.ack;
    res.start_status = st_nxt.start_code;
  end

endmodule : i2cm_step
`default_nettype wire

[rtl/core/i2c_master_bit_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Open-drain I2C master bit engine, one input word per engine tick.
// ----------------------------------------------------------------------------
// Each input word is one tick of the engine: an optional command, the byte to
// send and the sampled SDA level. Each accepted word yields exactly one result
// word with the SCL/SDA drive levels, busy, done, the last received byte, the
// last ack result and the last start status. One word is taken every cycle
// while the result side keeps up; it passes an input register and the tick
// logic and lands in the result register. The result and input registers
// each hold one word, so a stalled output side stops intake only once both
// are full. Every phase lasts phase_ticks ticks (zero acts as one); commands
// that arrive while busy are dropped. The user must write the phase_ticks
// register through the cfg port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  var logic                 clk,
  input  var logic                 rst_n,
  // input words
  input  var logic                 in_valid,
  output logic                     in_ready,
  input  var i2cm_pkg::i2cm_in_t   in_data,
  // result words
  output logic                     out_valid,
  input  var logic                 out_ready,
  output i2cm_pkg::i2cm_out_t      out_data,
  // configuration: phase_ticks
  input  var logic                 cfg_valid,
  output logic                     cfg_ready,
  input  var logic [15:0]          cfg_data
);
  import i2cm_pkg::*;

  logic [15:0]  phase_ticks_r;
  logic         in_vld_r;
  i2cm_in_t     in_item_r;
  logic         out_vld_r;
  i2cm_out_t    out_item_r;
  i2cm_state_t  st_r;
  i2cm_state_t  st_nxt;
  i2cm_out_t    res;
  logic         adv;

  // tick logic fires when a word waits and the result slot is free
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  i2cm_step u_step (
    .st          (st_r),
    .item        (in_item_r),
    .phase_ticks (phase_ticks_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r    <= PHASE_TICKS_RST;
      in_vld_r         <= 1'b0;
      out_vld_r        <= 1'b0;
      st_r.cmd         <= CMD_IDLE;
      st_r.step        <= 3'd0;
      st_r.bit_cnt     <= 4'd0;
      st_r.tick_cnt    <= 16'd0;
      st_r.shreg       <= 8'd0;
      st_r.rx_byte     <= 8'd0;
      st_r.scl         <= 1'b1;
      st_r.sda         <= 1'b1;
      st_r.ack         <= 1'b0;
      st_r.start_code  <= ST_OK;
    end else begin
      if (cfg_valid) phase_ticks_r <= cfg_data;
      // input register
      if (in_ready) in_vld_r <= in_valid;
      // engine state and result register
      if (adv) begin
        st_r      <= st_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_item_r <= in_data;
    if (adv) out_item_r <= res;
  end

endmodule : i2c_master_bit_engine
`default_nettype wire

[rtl/core/i2cm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input var logic                clk,
  input var logic                rst_n,
  input var logic                out_valid,
  input var logic                out_ready,
  input var i2cm_pkg::i2cm_out_t out_data
);
  import i2cm_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a finishing tick never reports busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done with busy set");

  // start status only takes defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.start_status != 2'd3)
    else $error("bad start status");

endmodule : i2cm_checker

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master bit engine. Every accepted input
// word runs through a local model of the engine; the predicted result word
// is queued and compared field by field with what the block returns. Both
// channels idle at random. phase_ticks is swept across 100 (reset), 1, 2, 0,
// 65535 and several small values.
// ----------------------------------------------------------------------------
module tb;
  import i2cm_pkg::*;

  // Slave behavior on SDA while a command runs.
  //   LINE_FOLLOW: line reads what the master drives; a slave may pull it low
  //                only where it owns the bus (read data, ack slot)
  //   LINE_NOISE : any level on any tick
  //   LINE_LOW / LINE_HIGH: line stuck at one level
  typedef enum {LINE_FOLLOW, LINE_NOISE, LINE_LOW, LINE_HIGH} line_mode_t;

  // Longest correct stretch with no handshake at all is a sender gap plus the
  // input and result registers plus a receiver stall. The limit is far above it.
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  i2cm_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  i2cm_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  i2c_master_bit_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Engine model: a copy of the engine state, advanced once per input word.
  // --------------------------------------------------------------------------
  logic [15:0] phase_ticks;
  i2cm_cmd_t   eng_cmd;
  logic [2:0]  eng_step;
  logic [3:0]  eng_bits;
  logic [15:0] eng_ticks;
  logic [7:0]  eng_shift;
  logic [7:0]  eng_rx;
  logic        eng_scl;
  logic        eng_sda;
  logic        eng_ack;
  i2cm_start_t eng_status;

  i2cm_out_t   predicted_outs[$];
  int          words_sent;
  int          results_seen;
  int          mismatches;
  bit          gaps_on;
  int          busy_cmd_pct;

  // Line levels set on entry to the current phase.
  function automatic void drive_phase();
    case (eng_cmd)
      CMD_START: begin
        if (eng_step == 0) begin
          eng_scl = 1'b1;
          eng_sda = 1'b1;
        end else begin
          eng_sda = 1'b0;
        end
      end
      CMD_STOP: begin
        case (eng_step)
          3'd0: eng_scl = 1'b0;
          3'd1: eng_sda = 1'b0;
          3'd2: eng_scl = 1'b1;
          default: eng_sda = 1'b1;
        endcase
      end
      CMD_ACK, CMD_NACK: begin
        case (eng_step)
          3'd0: eng_scl = 1'b0;
          3'd1: eng_sda = (eng_cmd == CMD_NACK);
          3'd2: eng_scl = 1'b1;
          default: eng_scl = 1'b0;
        endcase
      end
      CMD_WACK: begin
        case (eng_step)
          3'd0: eng_scl = 1'b0;
          3'd1: eng_sda = 1'b1;
          default: eng_scl = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        if (eng_step == 0) begin
          eng_scl = 1'b0;
          eng_sda = eng_shift[7];
        end else begin
          eng_scl = 1'b1;
        end
      end
      CMD_READ: begin
        if (eng_step == 0) begin
          eng_scl = 1'b0;
          eng_sda = 1'b1;
        end else begin
          eng_scl = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Closes the current phase with the sampled SDA level; 1 when the command ends.
  function automatic bit finish_phase(input logic sda);
    case (eng_cmd)
      CMD_START: begin
        if (eng_step == 0 && !sda) begin
          eng_status = ST_BUS_BUSY;
          return 1'b1;
        end
        if (eng_step == 1 && sda) begin
          eng_status = ST_STUCK_HIGH;
          return 1'b1;
        end
        if (eng_step == 2) begin
          eng_status = ST_OK;
          return 1'b1;
        end
      end
      CMD_STOP, CMD_ACK, CMD_NACK: begin
        if (eng_step == 3) return 1'b1;
      end
      CMD_WACK: begin
        if (eng_step == 2) begin
          eng_ack = !sda;
          eng_scl = 1'b0;
          return 1'b1;
        end
      end
      CMD_WRITE, CMD_READ: begin
        if (eng_step == 1) begin
          eng_shift = {eng_shift[6:0], (eng_cmd == CMD_READ) ? sda : 1'b0};
          eng_bits  = eng_bits + 4'd1;
          if (eng_bits >= BITS_PER_BYTE) begin
            if (eng_cmd == CMD_READ) eng_rx = eng_shift;
            eng_scl = 1'b0;
            return 1'b1;
          end
          // next bit starts over at the SCL-low phase
          eng_step = 3'd0;
          drive_phase();
          return 1'b0;
        end
      end
      default: return 1'b1;
    endcase
    eng_step = eng_step + 3'd1;
    drive_phase();
    return 1'b0;
  endfunction

  // One engine tick: returns the result word the block must give for w.
  function automatic i2cm_out_t engine_tick(input i2cm_in_t w);
    logic [15:0] limit;
    bit          finished;
    i2cm_out_t   r;
    limit    = (phase_ticks == 0) ? 16'd1 : phase_ticks;
    finished = 1'b0;
    if (eng_cmd == CMD_IDLE) begin
      if (w.req_type != CMD_IDLE) begin
        eng_cmd   = i2cm_cmd_t'(w.req_type);
        eng_step  = 3'd0;
        eng_bits  = 4'd0;
        eng_ticks = 16'd0;
        if (eng_cmd == CMD_WRITE) eng_shift = w.tx_byte;
        else if (eng_cmd == CMD_READ) eng_shift = 8'd0;
        drive_phase();
      end
    end else begin
      eng_ticks = eng_ticks + 16'd1;
      if (eng_ticks >= limit) begin
        eng_ticks = 16'd0;
        if (finish_phase(w.sda_in)) begin
          eng_cmd  = CMD_IDLE;
          eng_step = 3'd0;
          eng_bits = 4'd0;
          finished = 1'b1;
        end
      end
    end
    r.scl_out      = eng_scl;
    r.sda_out      = eng_sda;
    r.busy_res     = (eng_cmd != CMD_IDLE);
    r.done_res     = finished;
    r.rx_byte      = eng_rx;
    r.ack_seen     = eng_ack;
    r.start_status = eng_status;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offers one word after a random gap; predicts its result once accepted.
  // valid stays up after acceptance so back-to-back words need no toggle.
  task automatic send_tick(input i2cm_in_t w);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predicted_outs.push_back(engine_tick(w));
    words_sent++;
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_outs.size() != 0);
  endtask

  // Issues one command and keeps ticking until the model says it is done.
  // Words sent while busy carry random requests that the engine must drop.
  task automatic run_command(input i2cm_cmd_t cmd, input logic [7:0] tx,
                             input line_mode_t mode);
    i2cm_in_t w;
    w.req_type = cmd;
    w.tx_byte  = tx;
    w.sda_in   = 1'($urandom_range(0, 1));
    send_tick(w);
    while (eng_cmd != CMD_IDLE) begin
      w.req_type = ($urandom_range(0, 99) < busy_cmd_pct) ?
                   3'($urandom_range(1, 7)) : CMD_IDLE;
      w.tx_byte  = 8'($urandom_range(0, 255));
      case (mode)
        LINE_LOW:   w.sda_in = 1'b0;
        LINE_HIGH:  w.sda_in = 1'b1;
        LINE_NOISE: w.sda_in = 1'($urandom_range(0, 1));
        default: begin
          if (!eng_sda) w.sda_in = 1'b0;
          else if (eng_cmd == CMD_READ || eng_cmd == CMD_WACK)
            w.sda_in = 1'($urandom_range(0, 1));
          else w.sda_in = 1'b1;
        end
      endcase
      // now and then the sender holds off mid-command until all results are in
      if ($urandom_range(0, 63) == 0) drain_outputs();
      send_tick(w);
    end
  endtask

  // Only written with the pipeline empty and the engine idle. Every word
  // yields a result, so a short pause after the drain is enough.
  task automatic write_phase_ticks(input logic [15:0] value);
    drain_outputs();
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    phase_ticks = value;
  endtask

  // Either a well-formed bus transaction or a burst of loose commands.
  task automatic random_transaction();
    int         n;
    line_mode_t mode;
    mode = ($urandom_range(0, 4) == 0) ? LINE_NOISE : LINE_FOLLOW;
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) run_command(i2cm_cmd_t'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)), mode);
    end else begin
      run_command(CMD_START, 8'($urandom_range(0, 255)), mode);
      run_command(CMD_WRITE, 8'($urandom_range(0, 255)), mode);  // address
      run_command(CMD_WACK, 8'($urandom_range(0, 255)), mode);
      n = $urandom_range(1, 3);
      if ($urandom_range(0, 1)) begin
        repeat (n) begin
          run_command(CMD_WRITE, 8'($urandom_range(0, 255)), mode);
          run_command(CMD_WACK, 8'($urandom_range(0, 255)), mode);
        end
      end else begin
        for (int i = 0; i < n; i++) begin
          run_command(CMD_READ, 8'($urandom_range(0, 255)), mode);
          // master nacks the last byte it wants
          run_command((i == n - 1) ? CMD_NACK : CMD_ACK,
                      8'($urandom_range(0, 255)), mode);
        end
      end
      run_command(CMD_STOP, 8'($urandom_range(0, 255)), mode);
    end
    repeat ($urandom_range(0, 2)) run_command(CMD_IDLE, 8'($urandom_range(0, 255)), mode);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset value of phase_ticks: a start on a held-low bus fails after 100 ticks.
  task automatic test_reset_defaults();
    run_command(CMD_IDLE, 8'h00, LINE_FOLLOW);
    run_command(CMD_START, 8'h00, LINE_LOW);
  endtask

  // Every command once, byte extremes, both ack results, all start outcomes.
  task automatic test_every_command();
    write_phase_ticks(16'd1);
    run_command(CMD_START, 8'h00, LINE_FOLLOW);
    run_command(CMD_WRITE, 8'h00, LINE_FOLLOW);
    run_command(CMD_WRITE, 8'hFF, LINE_FOLLOW);
    run_command(CMD_WACK, 8'h00, LINE_LOW);
    run_command(CMD_WRITE, 8'hA5, LINE_FOLLOW);
    run_command(CMD_WACK, 8'h00, LINE_HIGH);
    run_command(CMD_READ, 8'h00, LINE_HIGH);
    run_command(CMD_READ, 8'hFF, LINE_LOW);
    run_command(CMD_READ, 8'h00, LINE_FOLLOW);
    run_command(CMD_ACK, 8'h00, LINE_FOLLOW);
    run_command(CMD_NACK, 8'h00, LINE_FOLLOW);
    run_command(CMD_STOP, 8'h00, LINE_FOLLOW);
    run_command(CMD_START, 8'h00, LINE_HIGH);   // SDA never follows the pull
    run_command(CMD_START, 8'h00, LINE_LOW);    // bus already held low
  endtask

  // Every word during a command, finishing tick included, carries a request.
  task automatic test_requests_while_busy();
    write_phase_ticks(16'd2);
    busy_cmd_pct = 100;
    run_command(CMD_WRITE, 8'h5A, LINE_FOLLOW);
    run_command(CMD_READ, 8'h00, LINE_FOLLOW);
    run_command(CMD_STOP, 8'h00, LINE_FOLLOW);
    busy_cmd_pct = 25;
  endtask

  // A zero register must behave like one.
  task automatic test_zero_phase_ticks();
    write_phase_ticks(16'd0);
    random_transaction();
    random_transaction();
  endtask

  // Largest register value on idle words, then one long phase with no idling.
  task automatic test_longest_phase();
    write_phase_ticks(16'hFFFF);
    run_command(CMD_IDLE, 8'h00, LINE_FOLLOW);
    run_command(CMD_IDLE, 8'hFF, LINE_FOLLOW);
    write_phase_ticks(16'd250);
    gaps_on = 1'b0;
    run_command(CMD_START, 8'h00, LINE_LOW);
    gaps_on = 1'b1;
  endtask

  // Bulk traffic over a few small settings; one segment runs with no idling.
  task automatic test_random_traffic();
    logic [15:0] tick_settings[4];
    int          seg_end;
    tick_settings = '{16'd1, 16'd2, 16'($urandom_range(1, 5)), 16'd3};
    for (int s = 0; s < 4; s++) begin
      write_phase_ticks(tick_settings[s]);
      gaps_on = (s != 2);
      seg_end = words_sent + 300;
      while (words_sent < seg_end) random_transaction();
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, every accepted word checked against the queue
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    $display("result %0d: %s is %0h, expected %0h", results_seen, field, got, want);
  endtask

  initial begin : result_side
    int        stall;
    i2cm_out_t got;
    i2cm_out_t want;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = gaps_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (predicted_outs.size() == 0) begin
        report_mismatch("unexpected word", int'(got), 0);
      end else begin
        want = predicted_outs.pop_front();
        if (got.scl_out !== want.scl_out)
          report_mismatch("scl_out", got.scl_out, want.scl_out);
        if (got.sda_out !== want.sda_out)
          report_mismatch("sda_out", got.sda_out, want.sda_out);
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.done_res !== want.done_res)
          report_mismatch("done_res", got.done_res, want.done_res);
        if (got.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.ack_seen !== want.ack_seen)
          report_mismatch("ack_seen", got.ack_seen, want.ack_seen);
        if (got.start_status !== want.start_status)
          report_mismatch("start_status", got.start_status, want.start_status);
      end
      results_seen++;
    end
  end

  // Watchdog: any handshake on any channel restarts the count.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // model starts from the reset state
    phase_ticks  = PHASE_TICKS_RST;
    eng_cmd      = CMD_IDLE;
    eng_step     = 3'd0;
    eng_bits     = 4'd0;
    eng_ticks    = 16'd0;
    eng_shift    = 8'd0;
    eng_rx       = 8'd0;
    eng_scl      = 1'b1;
    eng_sda      = 1'b1;
    eng_ack      = 1'b0;
    eng_status   = ST_OK;
    words_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    gaps_on      = 1'b1;
    busy_cmd_pct = 25;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_every_command();
    test_requests_while_busy();
    test_zero_phase_ticks();
    test_longest_phase();
    test_random_traffic();

    // let the pipeline empty, then wait for anything stray
    drain_outputs();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
